// ----- design/binary_min_heap_queue_top_assert.svh -----
// assertion macros for the heap queue block
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BMHQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// expression must never be true outside reset
`define BMHQ_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define BMHQ_ASSERT(lbl, clk, rst, prop)
`define BMHQ_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- design/bmhq_pkg.sv -----
// shared types and constants for the heap queue block
package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        count_t;

  localparam count_t CAP_COUNT = CNT_W'(CAPACITY);

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

endpackage

// ----- design/bmhq_cell.sv -----
// one cell of the sorted key chain: holds one key, shifts on push and pop
module bmhq_cell (
  input  logic                clk,
  input  bmhq_pkg::cell_cmd_t cmd,
  input  bmhq_pkg::key_t      key_in,
  input  logic                occupied,
  input  logic                left_ins,
  input  bmhq_pkg::key_t      left_key,
  input  bmhq_pkg::key_t      right_key,
  output logic                ins,
  output bmhq_pkg::key_t      key
);
  import bmhq_pkg::*;

  // new key lands at or before this cell; equal keys keep the older one first
  assign ins = !occupied || (key_in < key);

  always_ff @(posedge clk) begin
    if (cmd.push && ins) begin
      // first inserting cell takes the new key, the rest take the left key
      key <= left_ins ? left_key : key_in;
    end else if (cmd.pop) begin
      key <= right_key;
    end
  end

endmodule

// ----- design/bmhq_chain.sv -----
// row of cells kept in ascending order, head cell holds the minimum
module bmhq_chain (
  input  logic                clk,
  input  bmhq_pkg::cell_cmd_t cmd,
  input  bmhq_pkg::key_t      key_in,
  input  bmhq_pkg::count_t    count,
  output bmhq_pkg::key_t      head_key
);
  import bmhq_pkg::*;

  key_t                keys [CAPACITY];
  logic [CAPACITY-1:0] ins;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occupied;
    logic left_ins;
    key_t left_key;
    key_t right_key;

    assign occupied  = count > CNT_W'(i);
    assign left_ins  = (i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1];
    assign left_key  = (i == 0) ? key_in : keys[(i == 0) ? 0 : i - 1];
    assign right_key = (i == CAPACITY - 1) ? keys[i] : keys[(i == CAPACITY - 1) ? i : i + 1];

    bmhq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key_in    (key_in),
      .occupied  (occupied),
      .left_ins  (left_ins),
      .left_key  (left_key),
      .right_key (right_key),
      .ins       (ins[i]),
      .key       (keys[i])
    );
  end

  assign head_key = keys[0];

endmodule

// ----- design/binary_min_heap_queue_top.sv -----
// Min-priority queue of signed 32-bit keys, up to 64 entries, held as a row of
// cells kept in ascending order. A word is taken at the edge where start is
// high; busy never rises, so one word can be taken every cycle. Each word gives
// exactly one result, shown on the result ports for the following cycle with
// done high: the minimum (zero when empty), the empty flag, the entry count and
// the error code. The receiver cannot stall it. All cells compare the incoming
// key in parallel and shift one place in a single step. A push while full or a
// pop while empty is refused and leaves the queue untouched. After reset the
// queue is empty and usable at once.
module binary_min_heap_queue_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             mode,
  input  bmhq_pkg::key_t   key_in,
  output logic             done,
  output bmhq_pkg::key_t   min_key,
  output logic             is_empty,
  output bmhq_pkg::count_t entry_count,
  output bmhq_pkg::err_t   error_code
);
  import bmhq_pkg::*;

  `include "binary_min_heap_queue_top_assert.svh"

  count_t    count;
  count_t    count_next;
  err_t      err;
  err_t      err_next;
  cell_cmd_t cmd;
  logic      accept;
  key_t      head_key;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    err_next   = ERR_OK;
    count_next = count;
    if (accept) begin
      if (mode == MODE_PUSH) begin
        if (count == CAP_COUNT) begin
          err_next = ERR_FULL;
        end else begin
          cmd.push   = 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        if (count == '0) begin
          err_next = ERR_EMPTY;
        end else begin
          cmd.pop    = 1'b1;
          count_next = count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      err   <= ERR_OK;
    end else begin
      count <= count_next;
      done  <= accept;
      err   <= err_next;
    end
  end

  bmhq_chain u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .key_in   (key_in),
    .count    (count),
    .head_key (head_key)
  );

  assign is_empty    = (count == '0);
  assign min_key     = is_empty ? '0 : head_key;
  assign entry_count = count;
  assign error_code  = err;

  `BMHQ_ASSERT(a_done_follows_accept, clk, rst, accept |=> done)
  `BMHQ_ASSERT(a_no_spurious_done, clk, rst, !accept |=> !done)
  `BMHQ_NEVER(a_count_in_range, clk, rst, count > CAP_COUNT)
  `BMHQ_ASSERT(a_full_flag_means_full, clk, rst,
    (done && error_code == ERR_FULL) |-> (entry_count == CAP_COUNT))
  `BMHQ_ASSERT(a_empty_pop_keeps_empty, clk, rst,
    (accept && mode == MODE_POP && count == '0) |=> (count == '0 && error_code == ERR_EMPTY))

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the heap queue block, with a heap predictor and scoreboard
`timescale 1ns / 100ps

import bmhq_pkg::*;

typedef struct {
  key_t   min_key;
  logic   is_empty;
  count_t count;
  err_t   err;
} heap_result_t;

class heap_tracker;
  key_t         heap[CAPACITY];
  int unsigned  fill;
  heap_result_t pending[$];
  int           mismatches;

  function new();
    fill = 0;
    mismatches = 0;
  endfunction

  task report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function void heap_push(key_t k);
    int unsigned i;
    int unsigned up;
    key_t        t;
    i = fill;
    heap[i] = k;
    fill++;
    while (i != 0) begin
      up = (i - 1) / 2;
      if (heap[i] >= heap[up]) break;
      t = heap[i];
      heap[i] = heap[up];
      heap[up] = t;
      i = up;
    end
  endfunction

  function void heap_pop_min();
    int unsigned i;
    int unsigned lc;
    int unsigned pick;
    key_t        t;
    i = 0;
    fill--;
    heap[0] = heap[fill];
    forever begin
      lc = 2 * i + 1;
      if (lc >= fill) break;
      // left child wins on ties; a lone left child is compared by itself
      pick = (lc + 1 < fill && heap[lc + 1] < heap[lc]) ? lc + 1 : lc;
      if (heap[i] <= heap[pick]) break;
      t = heap[i];
      heap[i] = heap[pick];
      heap[pick] = t;
      i = pick;
    end
  endfunction

  // called for every accepted word
  function void note_word(mode_t m, key_t k);
    heap_result_t r;
    r.err = ERR_OK;
    if (m == MODE_PUSH) begin
      if (fill >= CAPACITY) r.err = ERR_FULL;
      else heap_push(k);
    end else begin
      if (fill == 0) r.err = ERR_EMPTY;
      else heap_pop_min();
    end
    r.is_empty = (fill == 0);
    r.min_key  = (fill == 0) ? key_t'(0) : heap[0];
    r.count    = count_t'(fill);
    pending = {pending, r};
  endfunction

  task check_result(key_t mk, logic emp, count_t cnt, err_t err);
    heap_result_t r;
    if (pending.size() == 0) begin
      report($sformatf("result with nothing expected (min %0d count %0d)", mk, cnt));
      return;
    end
    r = pending.pop_front();
    if (mk !== r.min_key)
      report($sformatf("min_key %0d, expected %0d", mk, r.min_key));
    if (emp !== r.is_empty)
      report($sformatf("is_empty %0b, expected %0b", emp, r.is_empty));
    if (cnt !== r.count)
      report($sformatf("entry_count %0d, expected %0d", cnt, r.count));
    if (err !== r.err)
      report($sformatf("error_code %0d, expected %0d", err, r.err));
  endtask
endclass

module tb_top;
  localparam int RANDOM_WORDS = 750;
  localparam int CYCLE_LIMIT  = 200000;

  logic   clk = 1'b0;
  logic   rst;
  logic   start;
  logic   busy;
  logic   mode;
  key_t   key_in;
  logic   done;
  key_t   min_key;
  logic   is_empty;
  count_t entry_count;
  err_t   error_code;

  heap_tracker tracker;
  int          sent;
  int          cycles;

  binary_min_heap_queue_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key_in      (key_in),
    .done        (done),
    .min_key     (min_key),
    .is_empty    (is_empty),
    .entry_count (entry_count),
    .error_code  (error_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // outputs are read at the rising edge, before the block updates them
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_word(mode_t'(mode), key_in);
      if (done) tracker.check_result(min_key, is_empty, entry_count, error_code);
    end
  end

  task automatic send_word(input mode_t m, input key_t k);
    int gap;
    // no idling in a middle stretch of the run
    gap = 0;
    if (sent < 300 || sent >= 450) begin
      while ($urandom_range(99) < 38) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      mode <= 1'($urandom_range(1));
      key_in <= $urandom;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    mode <= m;
    key_in <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(9))
      0, 1, 2, 3: pick_key = $urandom;
      4, 5, 6:    pick_key = key_t'($urandom_range(15)) - 8;
      7:          pick_key = key_t'(32'h7fff_ffff) - key_t'($urandom_range(3));
      8:          pick_key = key_t'(32'h8000_0000) + key_t'($urandom_range(3));
      default:    pick_key = key_t'($urandom_range(3)) - 2;
    endcase
  endfunction

  initial begin
    int     bias;
    int     steps;
    mode_t  m;
    tracker = new();
    sent = 0;
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_PUSH;
    key_in = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pop, key extremes, equal keys, drain past empty
    send_word(MODE_POP, 32'h1234_5678);
    send_word(MODE_PUSH, 32'h7fff_ffff);
    send_word(MODE_PUSH, 32'h8000_0000);
    send_word(MODE_PUSH, 32'h0000_0000);
    send_word(MODE_PUSH, 32'hffff_ffff);
    send_word(MODE_PUSH, 32'sd5);
    send_word(MODE_PUSH, 32'sd5);
    send_word(MODE_PUSH, 32'sd5);
    repeat (7) send_word(MODE_POP, $urandom);
    send_word(MODE_POP, 32'hffff_ffff);

    // random phases: filling runs into full, draining runs past empty
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(2))
        0:       bias = 85;
        1:       bias = 15;
        default: bias = 50;
      endcase
      steps = $urandom_range(40, 120);
      repeat (steps) begin
        if (sent < RANDOM_WORDS) begin
          m = ($urandom_range(99) < bias) ? MODE_PUSH : MODE_POP;
          send_word(m, pick_key());
        end
      end
    end
    start <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending.size()));
    if (tracker.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ----- binary_min_heap_queue_top.f -----
+incdir+design
design/bmhq_pkg.sv
design/bmhq_cell.sv
design/bmhq_chain.sv
design/binary_min_heap_queue_top.sv
sim/tb_top.sv
